FILE: rtl/core/fbfl_pkg.sv
// shared types and constants of the fixed block free list allocator
package fbfl_pkg;

	localparam int MAX_BLOCKS      = 1024;
	localparam int IDX_W           = $clog2(MAX_BLOCKS);
	localparam int CNT_W           = 11;
	localparam int SIZE_W          = 13;
	localparam int ADDR_W          = 32;
	localparam int LIM_W           = CNT_W + SIZE_W;
	localparam int DIV_W           = IDX_W + SIZE_W;
	localparam int CFG_IDX_W       = 2;
	localparam int CFG_W           = 32;
	localparam int MIN_BLOCK_BYTES = 8;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
	localparam logic [1:0] ST_NONE_USED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd2;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] free_address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] block_address;
		logic [CNT_W-1:0]  in_use;
	} rsp_t;

	typedef struct packed {
		logic             rd;
		logic             pop;
		logic             push;
		logic [IDX_W-1:0] idx;
	} list_cmd_t;

	typedef struct packed {
		logic             ready;
		logic [CNT_W-1:0] head;
		logic [CNT_W-1:0] used;
	} list_stat_t;

	typedef struct packed {
		logic             done;
		logic             rem_zero;
		logic [IDX_W-1:0] quot;
	} div_res_t;

endpackage

FILE: rtl/core/fbfl_list.sv
// next-pointer store with free list head, in-use count and reset fill sweep
module fbfl_list (
	input  logic                clk,
	input  logic                arst_n,
	input  fbfl_pkg::list_cmd_t cmd,
	output fbfl_pkg::list_stat_t stat
);
	import fbfl_pkg::*;

	logic [CNT_W-1:0] mem [MAX_BLOCKS];
	logic [CNT_W-1:0] rd_data_q;
	logic [CNT_W-1:0] head_q;
	logic [CNT_W-1:0] used_q;
	logic [CNT_W-1:0] init_q;
	logic             init_busy;

	assign init_busy = (init_q != CNT_W'(MAX_BLOCKS));

	// single write port: fill sweep or push
	always_ff @(posedge clk) begin
		if (init_busy) begin
			mem[init_q[IDX_W-1:0]] <= init_q + CNT_W'(1);
		end else if (cmd.push) begin
			mem[cmd.idx] <= head_q;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[head_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= '0;
			head_q <= '0;
			used_q <= '0;
		end else begin
			if (init_busy) begin
				init_q <= init_q + CNT_W'(1);
			end
			if (cmd.pop) begin
				head_q <= rd_data_q;
				used_q <= used_q + CNT_W'(1);
			end else if (cmd.push) begin
				head_q <= CNT_W'(cmd.idx);
				used_q <= used_q - CNT_W'(1);
			end
		end
	end

	assign stat.ready = !init_busy;
	assign stat.head  = head_q;
	assign stat.used  = used_q;

endmodule

FILE: rtl/core/fbfl_div.sv
// restoring divider, one quotient bit per cycle, for offset to block index
module fbfl_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [fbfl_pkg::DIV_W-1:0] dividend,
	input  logic [fbfl_pkg::SIZE_W-1:0] divisor,
	output fbfl_pkg::div_res_t         res
);
	import fbfl_pkg::*;

	localparam int STEP_W = $clog2(IDX_W + 1);

	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dsr_q;
	logic [IDX_W-1:0]  quot_q;
	logic              fits;

	assign fits = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(IDX_W);
		end else if (busy_q) begin
			step_q <= step_q - STEP_W'(1);
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			dsr_q  <= DIV_W'(divisor) << (IDX_W - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsr_q;
			end
			dsr_q  <= dsr_q >> 1;
			quot_q <= {quot_q[IDX_W-2:0], fits};
		end
	end

	assign res.done     = !busy_q;
	assign res.rem_zero = (rem_q == '0);
	assign res.quot     = quot_q;

endmodule

FILE: rtl/core/fixed_block_free_list_allocator_unit.sv
// Fixed-size block pool allocator: an allocate goes through a check with memory read of the
// next pointer, head update and result; a free goes through check and bound multiply, bound
// compare, the bit-serial index divider, push and result. A rejected request skips to the
// result. One request is worked on at a time; the next is accepted while the previous
// result waits in the output register. After reset the next-pointer memory is filled by a
// sweep over all 1024 entries, during which no request is accepted (configuration writes
// are taken). Double frees are not detected.
module fixed_block_free_list_allocator_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [fbfl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [fbfl_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  fbfl_pkg::req_t                in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output fbfl_pkg::rsp_t                out_data
);
	import fbfl_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_ALLOC = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_DIV   = 3'd4;
	localparam logic [2:0] S_RESP  = 3'd5;

	logic [2:0]        state_q;
	logic [ADDR_W-1:0] base_q;
	logic [SIZE_W-1:0] bytes_q;
	logic [CNT_W-1:0]  count_q;

	logic              op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [1:0]        status_q;
	logic [ADDR_W-1:0] baddr_q;
	logic [LIM_W-1:0]  prod_q;
	logic [ADDR_W-1:0] off_q;
	logic [LIM_W-1:0]  lim_q;
	logic              out_valid_q;
	rsp_t              out_q;

	logic [SIZE_W-1:0] eff_size;
	logic [CNT_W-1:0]  eff_cnt;
	logic              alloc_fail;
	logic              out_free;
	logic              div_start;

	list_cmd_t  cmd;
	list_stat_t stat;
	div_res_t   dres;

	fbfl_list u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (stat)
	);

	fbfl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (off_q[DIV_W-1:0]),
		.divisor  (eff_size),
		.res      (dres)
	);

	always_comb begin
		eff_size = (bytes_q < SIZE_W'(MIN_BLOCK_BYTES)) ? SIZE_W'(MIN_BLOCK_BYTES) : bytes_q;
		if (count_q == '0) begin
			eff_cnt = CNT_W'(1);
		end else if (count_q > CNT_W'(MAX_BLOCKS)) begin
			eff_cnt = CNT_W'(MAX_BLOCKS);
		end else begin
			eff_cnt = count_q;
		end
	end

	assign alloc_fail = (stat.used >= eff_cnt) || (stat.head >= eff_cnt);
	assign out_free   = !out_valid_q || out_ready;
	assign in_ready   = (state_q == S_IDLE) && stat.ready;
	assign div_start  = (state_q == S_CHECK) && (off_q < ADDR_W'(lim_q));

	always_comb begin
		cmd      = '0;
		cmd.idx  = dres.quot;
		cmd.rd   = (state_q == S_EVAL) && (op_q == OP_ALLOC) && !alloc_fail;
		cmd.pop  = (state_q == S_ALLOC);
		cmd.push = (state_q == S_DIV) && dres.done && dres.rem_zero;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= '0;
			bytes_q <= SIZE_W'(8);
			count_q <= CNT_W'(1024);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_POOL_BASE:   base_q  <= cfg_wdata[ADDR_W-1:0];
				REG_BLOCK_BYTES: bytes_q <= cfg_wdata[SIZE_W-1:0];
				REG_BLOCK_COUNT: count_q <= cfg_wdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (op_q == OP_ALLOC) begin
						state_q <= alloc_fail ? S_RESP : S_ALLOC;
					end else if (stat.used == '0 || addr_q < base_q) begin
						state_q <= S_RESP;
					end else begin
						state_q <= S_CHECK;
					end
				end
				S_ALLOC: state_q <= S_RESP;
				S_CHECK: state_q <= div_start ? S_DIV : S_RESP;
				S_DIV: begin
					if (dres.done) begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q     <= in_data.op;
				addr_q   <= in_data.free_address;
				status_q <= ST_OK;
				baddr_q  <= '0;
			end
			S_EVAL: begin
				prod_q <= LIM_W'(stat.head) * LIM_W'(eff_size);
				lim_q  <= LIM_W'(eff_cnt) * LIM_W'(eff_size);
				off_q  <= addr_q - base_q;
				if (op_q == OP_ALLOC) begin
					if (alloc_fail) begin
						status_q <= ST_EXHAUSTED;
					end
				end else if (stat.used == '0) begin
					status_q <= ST_NONE_USED;
				end else if (addr_q < base_q) begin
					status_q <= ST_BAD_ADDR;
				end
			end
			S_ALLOC: baddr_q <= base_q + ADDR_W'(prod_q);
			S_CHECK: begin
				if (!div_start) begin
					status_q <= ST_BAD_ADDR;
				end
			end
			S_DIV: begin
				if (dres.done && !dres.rem_zero) begin
					status_q <= ST_BAD_ADDR;
				end
			end
			S_RESP: begin
				if (out_free) begin
					out_q.status        <= status_q;
					out_q.block_address <= baddr_q;
					out_q.in_use        <= stat.used;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: tb/tb_fixed_block_free_list_allocator_unit.sv
// testbench for the fixed block free list allocator: directed and random traffic vs a model
module tb_fixed_block_free_list_allocator_unit;
	import fbfl_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 147;
	localparam int RANDOM_PHASES  = 7;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_POOL_BASE;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	req_t                 in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	rsp_t                 out_data;

	logic [CNT_W-1:0]  link_mem [MAX_BLOCKS];
	logic [CNT_W-1:0]  head_idx;
	logic [CNT_W-1:0]  used_blocks;
	logic [ADDR_W-1:0] base_reg;
	logic [SIZE_W-1:0] bytes_reg;
	logic [CNT_W-1:0]  count_reg;

	req_t              pending_reqs [$];
	rsp_t              expected_rsps [$];
	logic [ADDR_W-1:0] handed_out [$];

	int       mismatches   = 0;
	int       holds_asked  = 0;
	int       holds_done   = 0;
	int       hold_left    = 0;
	int       rx_cycle     = 0;
	rx_mode_t rx_mode      = RX_OPEN;
	int       burst_left   = 8;
	int       gap_left     = 0;
	int       quiet_cycles = 0;

	fixed_block_free_list_allocator_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int eff_bytes();
		return (bytes_reg < MIN_BLOCK_BYTES) ? MIN_BLOCK_BYTES : int'(bytes_reg);
	endfunction

	function automatic int eff_blocks();
		if (count_reg == 0)
			return 1;
		if (count_reg > MAX_BLOCKS)
			return MAX_BLOCKS;
		return int'(count_reg);
	endfunction

	function automatic rsp_t serve_request(input req_t rq);
		rsp_t       rs;
		logic [63:0] size;
		logic [63:0] blocks;
		logic [63:0] offset;
		size   = 64'(eff_bytes());
		blocks = 64'(eff_blocks());
		rs     = '0;
		rs.status = ST_OK;
		if (rq.op == OP_ALLOC) begin
			if (64'(used_blocks) >= blocks || 64'(head_idx) >= blocks) begin
				rs.status = ST_EXHAUSTED;
			end else begin
				rs.block_address = ADDR_W'(64'(base_reg) + 64'(head_idx) * size);
				handed_out.push_back(rs.block_address);
				head_idx    = link_mem[head_idx[IDX_W-1:0]];
				used_blocks = used_blocks + CNT_W'(1);
			end
		end else if (used_blocks == 0) begin
			rs.status = ST_NONE_USED;
		end else if (rq.free_address < base_reg) begin
			rs.status = ST_BAD_ADDR;
		end else begin
			offset = 64'(rq.free_address) - 64'(base_reg);
			if (offset >= blocks * size || offset % size != 0) begin
				rs.status = ST_BAD_ADDR;
			end else begin
				link_mem[IDX_W'(offset / size)] = head_idx;
				head_idx    = CNT_W'(offset / size);
				used_blocks = used_blocks - CNT_W'(1);
			end
		end
		rs.in_use = used_blocks;
		return rs;
	endfunction

	function automatic void queue_request(input logic op, input logic [ADDR_W-1:0] addr);
		req_t rq;
		rq.op           = op;
		rq.free_address = addr;
		pending_reqs.push_back(rq);
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
	endtask

	task automatic set_pool(input logic [ADDR_W-1:0] base, input int bytes, input int blocks);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_POOL_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_index <= REG_BLOCK_BYTES;
		cfg_wdata <= (CFG_W'($urandom()) << SIZE_W) | CFG_W'(bytes);
		@(posedge clk);
		cfg_index <= REG_BLOCK_COUNT;
		cfg_wdata <= (CFG_W'($urandom()) << CNT_W) | CFG_W'(blocks);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				in_valid <= 1'b1;
				in_data  <= pending_reqs.pop_front();
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver
	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycle <= rx_cycle + 1;
			if (rx_cycle % 96 == 0)
				rx_mode <= rx_mode_t'($urandom_range(0, 3));
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (holds_done != holds_asked) begin
				holds_done <= holds_done + 1;
				hold_left  <= HOLD_CYCLES;
				out_ready  <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   out_ready <= 1'b1;
					RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
					default:   out_ready <= rx_cycle[2];
				endcase
			end
		end
	end

	// monitor: config tracking, prediction on request beats, checking on result beats
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_POOL_BASE:   base_reg  = cfg_wdata;
					REG_BLOCK_BYTES: bytes_reg = cfg_wdata[SIZE_W-1:0];
					REG_BLOCK_COUNT: count_reg = cfg_wdata[CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_rsps.push_back(serve_request(in_data));
			if (out_valid && out_ready) begin
				if (expected_rsps.size() == 0) begin
					$error("result beat with no request outstanding: %h", out_data);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					if (out_data.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, out_data.status);
						mismatches++;
					end
					if (out_data.block_address !== want.block_address) begin
						$error("block_address: expected %h, actual %h",
							want.block_address, out_data.block_address);
						mismatches++;
					end
					if (out_data.in_use !== want.in_use) begin
						$error("in_use: expected %0d, actual %0d", want.in_use, out_data.in_use);
						mismatches++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("fixed_block_free_list_allocator_unit test failed");
			$finish;
		end
	end

	initial begin : stimulus
		int                alloc_pct;
		int                pick;
		int                k;
		int                sz;
		int                nb;
		logic [ADDR_W-1:0] addr;
		for (int i = 0; i < MAX_BLOCKS; i++)
			link_mem[IDX_W'(i)] = CNT_W'(i + 1);
		head_idx    = '0;
		used_blocks = '0;
		base_reg    = '0;
		bytes_reg   = SIZE_W'(8);
		count_reg   = CNT_W'(MAX_BLOCKS);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset configuration: free on empty pool, bad addresses, double free
		queue_request(OP_FREE, 32'h0000_0000);
		queue_request(OP_ALLOC, 32'hFFFF_FFFF);
		queue_request(OP_ALLOC, 32'h0000_0000);
		queue_request(OP_ALLOC, 32'h5555_AAAA);
		queue_request(OP_FREE, 32'hFFFF_FFFF);
		queue_request(OP_FREE, 32'h0000_0004);
		queue_request(OP_FREE, 32'h0000_2000);
		queue_request(OP_FREE, 32'h0000_0008);
		queue_request(OP_FREE, 32'h0000_0008);
		queue_request(OP_ALLOC, 32'h0000_0000);
		queue_request(OP_ALLOC, 32'h0000_0000);
		wait_idle();

		// size below minimum, count of zero, base near the top
		set_pool(32'hFFFF_FFF0, 0, 0);
		queue_request(OP_ALLOC, 32'h0000_0000);
		queue_request(OP_FREE, 32'h0000_0000);
		queue_request(OP_FREE, 32'hFFFF_FFF0);
		queue_request(OP_ALLOC, 32'h0000_0000);
		queue_request(OP_ALLOC, 32'h0000_0000);
		queue_request(OP_FREE, 32'hFFFF_FFF8);
		wait_idle();

		// size of 4096 bytes, count above the pool maximum
		set_pool(32'h0000_1000, 4096, 2047);
		queue_request(OP_FREE, 32'h0040_0000);
		queue_request(OP_ALLOC, 32'h0000_0000);
		queue_request(OP_FREE, 32'h0040_1000);
		queue_request(OP_FREE, 32'h0000_2800);
		queue_request(OP_ALLOC, 32'h0000_0000);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: set_pool(32'h0000_4000, 24, 16);
				1: set_pool(32'hFFFF_F000, 4096, 1024);
				2: set_pool($urandom(), 7, 2047);
				3: set_pool($urandom() & 32'hFFFF_FF00, $urandom_range(8, 4096),
					$urandom_range(1, 64));
				4: set_pool($urandom(), 4096, 1);
				5: set_pool(32'h0000_0000, 8, 3);
				default: set_pool(32'hFFFF_FFFF, $urandom_range(8, 200),
					$urandom_range(1, 1024));
			endcase
			if (ph == 1 || ph == 4)
				holds_asked++;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 32 == 0)
					alloc_pct = $urandom_range(15, 85);
				while (pending_reqs.size() >= 2)
					@(negedge clk);
				if ($urandom_range(0, 99) < alloc_pct) begin
					queue_request(OP_ALLOC, $urandom());
				end else begin
					sz   = eff_bytes();
					nb   = eff_blocks();
					pick = $urandom_range(0, 99);
					if (pick < 65 && handed_out.size() > 0) begin
						k    = $urandom_range(0, handed_out.size() - 1);
						addr = handed_out[k];
						handed_out.delete(k);
					end else if (pick < 82) begin
						addr = base_reg + ADDR_W'($urandom_range(0, nb + 1)) * ADDR_W'(sz);
					end else if (pick < 93) begin
						addr = base_reg + ADDR_W'($urandom_range(0, nb - 1)) * ADDR_W'(sz)
							+ ADDR_W'($urandom_range(1, sz - 1));
					end else begin
						addr = $urandom();
					end
					queue_request(OP_FREE, addr);
				end
			end
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("fixed_block_free_list_allocator_unit test passed");
		else
			$display("fixed_block_free_list_allocator_unit test failed");
		$finish;
	end

endmodule
